FILE: src/imu_att_pkg.sv
package imu_att_pkg;

  localparam int ITER_W     = 5;
  localparam int SQRT_STEPS = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [25:0] RAD_SCALE_K = 26'd44798134;
  localparam logic [31:0] Y_CREEP     = 32'd168;
  localparam logic [15:0] DEG_TURN_Q7 = 16'd46080;
  localparam logic [16:0] BLEND_ONE   = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_YAW_RATE_DEADBAND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_AXIS_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_LIMIT_US       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_SUBSTITUTE_US  = 3'd4;

  localparam logic [31:0] ATAN_TURN [0:29] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_Y, ST_SQ_Z, ST_SQRT_INIT, ST_SQRT, ST_CORDIC_INIT, ST_CORDIC,
    ST_RATE_M, ST_RATE_HI, ST_RATE_LO, ST_RATE_ACC, ST_BLEND_PW, ST_BLEND_AW,
    ST_BLEND
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL_AY, OP_MUL_AZ, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_CORDIC_INIT, OP_CORDIC_STEP, OP_RATE_M, OP_RATE_HI, OP_RATE_LO,
    OP_RATE_ACC, OP_BLEND_PW, OP_BLEND_AW, OP_BLEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [ITER_W-1:0] iter;
    logic              sel_yaw;
  } dp_cmd_t;

endpackage

FILE: src/imu_att_ifs.sv
interface imu_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] gyro_x_rate;
  logic [31:0] gyro_y_rate;
  logic [31:0] gyro_z_rate;
  logic [15:0] accel_x;
  logic [15:0] accel_y;
  logic [15:0] accel_z;
  logic [31:0] timestamp_us;

  modport source (output valid, gyro_x_rate, gyro_y_rate, gyro_z_rate, accel_x, accel_y,
                  accel_z, timestamp_us, input ready);
  modport sink (input valid, gyro_x_rate, gyro_y_rate, gyro_z_rate, accel_x, accel_y,
                accel_z, timestamp_us, output ready);
endinterface

interface imu_attitude_if;
  logic        valid;
  logic        ready;
  logic [15:0] roll_deg;
  logic [15:0] pitch_deg;
  logic [15:0] yaw_deg;

  modport source (output valid, roll_deg, pitch_deg, yaw_deg, input ready);
  modport sink (input valid, roll_deg, pitch_deg, yaw_deg, output ready);
endinterface

FILE: src/imu_att_ctrl.sv
module imu_att_ctrl import imu_att_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t            state, state_next;
  logic [ITER_W-1:0] iter;
  logic              sel_yaw;
  logic              fire;

  assign fire = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:        if (in_valid) state_next = ST_SQ_Y;
      ST_SQ_Y:        state_next = ST_SQ_Z;
      ST_SQ_Z:        state_next = ST_SQRT_INIT;
      ST_SQRT_INIT:   state_next = ST_SQRT;
      ST_SQRT:        if (iter == ITER_W'(SQRT_STEPS - 1)) state_next = ST_CORDIC_INIT;
      ST_CORDIC_INIT: state_next = ST_CORDIC;
      ST_CORDIC:      if (iter == ITER_W'(CORDIC_ITERATIONS - 1)) state_next = ST_RATE_M;
      ST_RATE_M:      state_next = ST_RATE_HI;
      ST_RATE_HI:     state_next = ST_RATE_LO;
      ST_RATE_LO:     state_next = ST_RATE_ACC;
      ST_RATE_ACC:    state_next = sel_yaw ? ST_BLEND_PW : ST_RATE_M;
      ST_BLEND_PW:    state_next = ST_BLEND_AW;
      ST_BLEND_AW:    state_next = ST_BLEND;
      ST_BLEND:       if (fire) state_next = ST_IDLE;
      default:        state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.iter    = iter;
    cmd.sel_yaw = sel_yaw;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_SQ_Y:        cmd.op = OP_MUL_AY;
      ST_SQ_Z:        cmd.op = OP_MUL_AZ;
      ST_SQRT_INIT:   cmd.op = OP_SQRT_INIT;
      ST_SQRT:        cmd.op = OP_SQRT_STEP;
      ST_CORDIC_INIT: cmd.op = OP_CORDIC_INIT;
      ST_CORDIC:      cmd.op = OP_CORDIC_STEP;
      ST_RATE_M:      cmd.op = OP_RATE_M;
      ST_RATE_HI:     cmd.op = OP_RATE_HI;
      ST_RATE_LO:     cmd.op = OP_RATE_LO;
      ST_RATE_ACC:    cmd.op = OP_RATE_ACC;
      ST_BLEND_PW:    cmd.op = OP_BLEND_PW;
      ST_BLEND_AW:    cmd.op = OP_BLEND_AW;
      ST_BLEND:       if (fire) cmd.op = OP_BLEND;
      default:        cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      sel_yaw   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      iter  <= (state_next == state) ? iter + ITER_W'(1) : '0;
      if (state == ST_IDLE) begin
        sel_yaw <= 1'b0;
      end else if (state == ST_RATE_ACC) begin
        sel_yaw <= 1'b1;
      end
      if (state == ST_BLEND && fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/imu_att_datapath.sv
module imu_att_datapath import imu_att_pkg::*; #(
  parameter int ANGLE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]           gyro_x_rate,
  input  logic [31:0]           gyro_y_rate,
  input  logic [15:0]           accel_x,
  input  logic [15:0]           accel_y,
  input  logic [15:0]           accel_z,
  input  logic [31:0]           timestamp_us,
  output logic [15:0]           roll_deg,
  output logic [15:0]           pitch_deg,
  output logic [15:0]           yaw_deg
);

  localparam int AB = ANGLE_BITS;

  function automatic logic [15:0] to_deg(input logic [AB-1:0] u);
    logic [AB+15:0] p;
    logic [15:0]    d;
    p = (AB + 16)'(u) * (AB + 16)'(DEG_TURN_Q7);
    d = p[AB+15:AB];
    if (u[AB-1]) d = d - DEG_TURN_Q7;
    return d;
  endfunction

  logic [15:0] blend_weight;
  logic [24:0] yaw_rate_deadband;
  logic [19:0] dt_limit_us, dt_substitute_us;

  logic          gyro_started, accel_started;
  logic [31:0]   previous_timestamp;
  logic [AB-1:0] roll_accumulator, yaw_accumulator;
  logic signed [31:0] pitch_filtered;

  logic [31:0] gx, gy, ts;
  logic [15:0] ax, ay, az;
  logic [19:0] dt;
  logic [31:0] sq;
  logic [47:0] sq_rem, sq_res;
  logic signed [27:0] cx, cy;
  logic signed [33:0] cz;
  logic        pitch_zero;
  logic signed [31:0] pitch_sample;
  logic [19:0] m_lo;
  logic [51:0] hik;
  logic signed [49:0] blend_acc;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [31:0] ts_diff, gx_mag, gy_mag, rate_mag;
  logic        gy_creep, rate_neg;
  logic [47:0] sq_bit, sq_trial;
  logic signed [27:0] cx_sh, cy_sh;
  logic signed [33:0] atan_step, cz_sh;
  logic [51:0] inc_sum;
  logic [AB-1:0] inc_a, delta;
  logic signed [49:0] blend_sum, blend_sh;
  logic signed [31:0] pitch_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight      <= 16'd64225;
      yaw_rate_deadband <= 25'd83886;
      dt_limit_us       <= 20'd30000;
      dt_substitute_us  <= 20'd15000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BLEND_WEIGHT:      blend_weight <= cfg_data[15:0];
        CFG_YAW_RATE_DEADBAND: yaw_rate_deadband <= cfg_data;
        CFG_DT_LIMIT_US:       dt_limit_us <= cfg_data[19:0];
        CFG_DT_SUBSTITUTE_US:  dt_substitute_us <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  assign ts_diff  = timestamp_us - previous_timestamp;
  assign gx_mag   = gx[31] ? (~gx + 32'd1) : gx;
  assign gy_mag   = gy[31] ? (~gy + 32'd1) : gy;
  assign gy_creep = (gy_mag != 32'd0) && (gy_mag < {7'd0, yaw_rate_deadband});
  assign rate_mag = cmd.sel_yaw ? (gy_creep ? Y_CREEP : gy_mag) : gx_mag;
  assign rate_neg = cmd.sel_yaw ? (!gy_creep && gy[31]) : gx[31];

  assign sq_bit   = 48'd1 << (6'd46 - {cmd.iter, 1'b0});
  assign sq_trial = sq_res + sq_bit;

  assign cx_sh     = cx >>> cmd.iter;
  assign cy_sh     = cy >>> cmd.iter;
  assign atan_step = {2'b00, ATAN_TURN[cmd.iter]};
  assign cz_sh     = cz >>> (32 - AB);

  assign inc_sum = hik + {26'd0, prod[45:20]};
  assign inc_a   = inc_sum[51 -: AB];
  assign delta   = rate_neg ? (~inc_a + AB'(1)) : inc_a;

  assign blend_sum  = blend_acc + prod[49:0];
  assign blend_sh   = blend_sum >>> 16;
  assign pitch_next = accel_started ? blend_sh[31:0] : pitch_sample;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MUL_AY: begin
        mul_a = 33'(signed'(ay));
        mul_b = 33'(signed'(ay));
      end
      OP_MUL_AZ: begin
        mul_a = 33'(signed'(az));
        mul_b = 33'(signed'(az));
      end
      OP_RATE_M: begin
        mul_a = {1'b0, rate_mag};
        mul_b = {13'd0, dt};
      end
      OP_RATE_HI: begin
        mul_a = {1'b0, prod[51:20]};
        mul_b = {7'd0, RAD_SCALE_K};
      end
      OP_RATE_LO: begin
        mul_a = {13'd0, m_lo};
        mul_b = {7'd0, RAD_SCALE_K};
      end
      OP_BLEND_PW: begin
        mul_a = {pitch_filtered[31], pitch_filtered};
        mul_b = {17'd0, blend_weight};
      end
      OP_BLEND_AW: begin
        mul_a = {pitch_sample[31], pitch_sample};
        mul_b = {16'd0, BLEND_ONE - {1'b0, blend_weight}};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op != OP_NONE) prod <= mul_a * mul_b;
    unique case (cmd.op)
      OP_LOAD: begin
        gx <= gyro_x_rate;
        gy <= gyro_y_rate;
        ax <= accel_x;
        ay <= accel_y;
        az <= accel_z;
        ts <= timestamp_us;
        dt <= (ts_diff > {12'd0, dt_limit_us}) ? dt_substitute_us : ts_diff[19:0];
      end
      OP_MUL_AZ: sq <= prod[31:0];
      OP_SQRT_INIT: begin
        sq_rem <= {sq + prod[31:0], 16'd0};
        sq_res <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_rem >= sq_trial) begin
          sq_rem <= sq_rem - sq_trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
      end
      OP_CORDIC_INIT: begin
        cx <= signed'(28'(sq_res));
        cy <= 28'(signed'({ax, 8'd0}));
        cz <= '0;
        pitch_zero <= (sq_res == 48'd0) && (ax == 16'd0);
      end
      OP_CORDIC_STEP: begin
        if (!cy[27]) begin
          cx <= cx + cy_sh;
          cy <= cy - cx_sh;
          cz <= cz + atan_step;
        end else begin
          cx <= cx - cy_sh;
          cy <= cy + cx_sh;
          cz <= cz - atan_step;
        end
      end
      OP_RATE_M: pitch_sample <= pitch_zero ? 32'sd0 : cz_sh[31:0];
      OP_RATE_HI: m_lo <= prod[19:0];
      OP_RATE_LO: hik <= prod[51:0];
      OP_BLEND_AW: blend_acc <= prod[49:0];
      OP_BLEND: begin
        roll_deg  <= to_deg(roll_accumulator);
        pitch_deg <= to_deg(pitch_next[AB-1:0]);
        yaw_deg   <= to_deg(yaw_accumulator);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_started       <= 1'b0;
      accel_started      <= 1'b0;
      previous_timestamp <= '0;
      roll_accumulator   <= '0;
      yaw_accumulator    <= '0;
      pitch_filtered     <= '0;
    end else begin
      if (cmd.op == OP_RATE_ACC && gyro_started) begin
        if (cmd.sel_yaw) begin
          yaw_accumulator <= yaw_accumulator - delta;
        end else begin
          roll_accumulator <= roll_accumulator + delta;
        end
      end
      if (cmd.op == OP_BLEND) begin
        gyro_started       <= 1'b1;
        accel_started      <= 1'b1;
        previous_timestamp <= ts;
        pitch_filtered     <= pitch_next;
      end
    end
  end

endmodule

FILE: src/imu_attitude_complementary.sv
// One sample yields one attitude item. A new sample is taken only in idle, after the
// previous one has passed the squares, the 24-step square root, the one-step-per-cycle
// CORDIC, the rate steps and the blend on the shared multiplier; the blend waits while
// the output register still holds a result that has not been taken.
// A finished result waits in the output register while the next sample runs.
// Synchronous reset clears angles, start flags and timestamp, and loads register defaults.
module imu_attitude_complementary import imu_att_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_BITS        = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  imu_sample_if.sink            sample,
  imu_attitude_if.source        attitude,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  imu_att_ctrl #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (attitude.valid),
    .out_ready (attitude.ready),
    .cmd       (cmd)
  );

  imu_att_datapath #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .gyro_x_rate  (sample.gyro_x_rate),
    .gyro_y_rate  (sample.gyro_y_rate),
    .accel_x      (sample.accel_x),
    .accel_y      (sample.accel_y),
    .accel_z      (sample.accel_z),
    .timestamp_us (sample.timestamp_us),
    .roll_deg     (attitude.roll_deg),
    .pitch_deg    (attitude.pitch_deg),
    .yaw_deg      (attitude.yaw_deg)
  );

endmodule

FILE: bench/imu_attitude_checker.sv
`timescale 1ns / 100ps

module imu_attitude_checker import imu_att_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  imu_sample_if                 sample,
  imu_attitude_if               attitude,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending,
  output int                    results_seen
);

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] yaw;
  } attitude_t;

  attitude_t   attitude_queue[$];
  logic [15:0] weight;
  logic [24:0] yaw_band;
  logic [24:0] roll_band;
  logic [19:0] dt_limit;
  logic [19:0] dt_sub;
  logic        gyro_run;
  logic        accel_run;
  logic [31:0] last_ts;
  logic [31:0] roll_angle;
  logic [31:0] yaw_angle;
  longint      pitch_angle;

  function automatic longint shift_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [31:0] rate_step(longint r, longint unsigned dt);
    longint unsigned m;
    longint unsigned k;
    longint unsigned inc;
    k = 64'd44798134;
    m = (r < 0 ? -r : r) * dt;
    inc = (((m >> 20) * k) + (((m & 64'hFFFFF) * k) >> 20)) >> 20;
    if (r < 0) inc = -inc;
    return inc[31:0];
  endfunction

  function automatic logic [15:0] angle_deg(logic [31:0] a);
    longint d;
    d = longint'((64'(a) * 64'd46080) >> 32);
    if (a[31]) d -= 46080;
    return d[15:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint tilt_angle(longint ax, longint ay, longint az);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    x = longint'(int_sqrt(64'(ay * ay + az * az) << 16));
    y = ax * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      dx = shift_floor(y, i);
      dy = shift_floor(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ATAN_TURN[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ATAN_TURN[i]);
      end
    end
    return z;
  endfunction

  function automatic attitude_t predict_attitude(
      logic [31:0] gx, logic [31:0] gy, logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
      logic [31:0] ts);
    longint unsigned dt;
    longint rate_y;
    longint a;
    attitude_t res;
    if (!gyro_run) begin
      gyro_run = 1'b1;
      last_ts = ts;
    end else begin
      dt = 64'(ts - last_ts);
      if (dt > dt_limit) dt = dt_sub;
      last_ts = ts;
      rate_y = longint'(signed'(gy));
      if (rate_y != 0 && (rate_y < 0 ? -rate_y : rate_y) < longint'(yaw_band)) rate_y = 168;
      roll_angle = roll_angle + rate_step(longint'(signed'(gx)), dt);
      yaw_angle = yaw_angle - rate_step(rate_y, dt);
    end
    a = tilt_angle(longint'(signed'(ax)), longint'(signed'(ay)), longint'(signed'(az)));
    if (!accel_run) begin
      accel_run = 1'b1;
      pitch_angle = a;
    end else begin
      pitch_angle = shift_floor(pitch_angle * longint'(weight) +
                                a * (65536 - longint'(weight)), 16);
    end
    res.roll = angle_deg(roll_angle);
    res.pitch = angle_deg(pitch_angle[31:0]);
    res.yaw = angle_deg(yaw_angle);
    return res;
  endfunction

  always @(posedge clk) begin
    attitude_t got;
    attitude_t want;
    int        bad;
    bad = 0;
    if (rst) begin
      weight <= 16'd64225;
      yaw_band <= 25'd83886;
      roll_band <= 25'd116601;
      dt_limit <= 20'd30000;
      dt_sub <= 20'd15000;
      gyro_run = 1'b0;
      accel_run = 1'b0;
      last_ts = '0;
      roll_angle = '0;
      yaw_angle = '0;
      pitch_angle = 0;
      attitude_queue.delete();
      errors <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_BLEND_WEIGHT: weight <= cfg_data[15:0];
          CFG_YAW_RATE_DEADBAND: yaw_band <= cfg_data;
          CFG_ROLL_AXIS_DEADBAND: roll_band <= cfg_data;
          CFG_DT_LIMIT_US: dt_limit <= cfg_data[19:0];
          CFG_DT_SUBSTITUTE_US: dt_sub <= cfg_data[19:0];
          default: ;
        endcase
      end
      if (attitude.valid && attitude.ready) begin
        got = '{attitude.roll_deg, attitude.pitch_deg, attitude.yaw_deg};
        results_seen <= results_seen + 1;
        if (attitude_queue.size() == 0) begin
          $error("Attitude item with no sample pending.");
          bad++;
        end else begin
          want = attitude_queue.pop_front();
          if (got.roll !== want.roll) begin
            $error("roll_deg expected %0d actual %0d", $signed(want.roll), $signed(got.roll));
            bad++;
          end
          if (got.pitch !== want.pitch) begin
            $error("pitch_deg expected %0d actual %0d", $signed(want.pitch),
                   $signed(got.pitch));
            bad++;
          end
          if (got.yaw !== want.yaw) begin
            $error("yaw_deg expected %0d actual %0d", $signed(want.yaw), $signed(got.yaw));
            bad++;
          end
        end
      end
      if (sample.valid && sample.ready) begin
        attitude_queue.push_back(predict_attitude(sample.gyro_x_rate, sample.gyro_y_rate,
            sample.accel_x, sample.accel_y, sample.accel_z, sample.timestamp_us));
      end
      errors <= errors + bad;
      pending <= attitude_queue.size();
    end
  end

endmodule

FILE: bench/imu_attitude_complementary_tb.sv
`timescale 1ns / 100ps

module imu_attitude_complementary_tb import imu_att_pkg::*;;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    results_seen;
  int                    quiet_cycles;
  int                    samples_sent;
  logic                  drain_phase;
  logic [31:0]           clock_us;

  imu_sample_if   sample ();
  imu_attitude_if attitude ();

  imu_attitude_complementary dut (
    .clk(clk), .rst(rst), .sample(sample), .attitude(attitude),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  imu_attitude_checker checker_inst (
    .clk(clk), .rst(rst), .sample(sample), .attitude(attitude),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    drain_phase = 1'b0;
    sample.valid = 1'b0;
    sample.gyro_x_rate = '0;
    sample.gyro_y_rate = '0;
    sample.gyro_z_rate = '0;
    sample.accel_x = '0;
    sample.accel_y = '0;
    sample.accel_z = '0;
    sample.timestamp_us = '0;
    attitude.ready = 1'b0;
  end

  always @(posedge clk) begin
    int gap;
    if (rst) begin
      attitude.ready <= 1'b0;
    end else if (drain_phase || $urandom_range(0, 3) != 0) begin
      attitude.ready <= 1'b1;
    end else begin
      attitude.ready <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || sample.valid && sample.ready || attitude.valid && attitude.ready)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    sample.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] gx, logic [31:0] gy, logic [31:0] gz,
                             logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                             logic [31:0] ts, bit idle_ok);
    if (idle_ok && !drain_phase && $urandom_range(0, 5) == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.gyro_x_rate <= gx;
    sample.gyro_y_rate <= gy;
    sample.gyro_z_rate <= gz;
    sample.accel_x <= ax;
    sample.accel_y <= ay;
    sample.accel_z <= az;
    sample.timestamp_us <= ts;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 200000)) - 100000);
      2: return 32'($signed($urandom_range(0, 50000000)) - 25000000);
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [15:0] pick_accel();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic random_samples(int count);
    logic [31:0] step;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: step = $urandom();
        1: step = $urandom_range(29000, 1100000);
        default: step = $urandom_range(0, 30000);
      endcase
      clock_us += step;
      send_sample(pick_rate(), pick_rate(), $urandom(), pick_accel(), pick_accel(),
                  pick_accel(), clock_us, 1'b1);
    end
  endtask

  initial begin
    samples_sent = 0;
    clock_us = 32'hFFFF0000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h0, 16'h7FFF, 16'h0, 16'h0, clock_us, 1'b0);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'h8000, 16'h8000, 16'h8000,
                clock_us + 32'd10000, 1'b0);
    send_sample(32'd0, 32'd0, 32'd0, 16'h0, 16'h0, 16'h0, clock_us + 32'd20000, 1'b0);
    send_sample(32'd100, 32'd100, 32'd5, 16'h0, 16'h7FFF, 16'h0, clock_us + 32'd25000, 1'b0);
    send_sample(32'hFFFFFF00, 32'hFFFFFF9C, 32'd1, 16'h8000, 16'h0, 16'h7FFF,
                clock_us + 32'd90000, 1'b0);
    send_sample(32'd16777216, 32'hFF000000, 32'd0, 16'd1, 16'hFFFF, 16'd1,
                32'h00001000, 1'b0);
    send_sample(32'hFFFFFFFF, 32'h00000001, 32'd0, 16'hFFFF, 16'h0, 16'h0,
                32'h00001000, 1'b0);
    send_sample(32'd83885, 32'd83886, 32'd0, 16'd1000, 16'd0, 16'd16000,
                32'h00008530, 1'b0);
    send_sample(32'h55555555, 32'hAAAAAAAA, 32'h5A5A5A5A, 16'h5555, 16'hAAAA, 16'h5555,
                32'h00008531, 1'b0);
    clock_us = 32'h00008531;
    random_samples(40);
    wait_idle();

    write_reg(CFG_BLEND_WEIGHT, 25'd0);
    write_reg(CFG_YAW_RATE_DEADBAND, 25'd16777216);
    write_reg(CFG_ROLL_AXIS_DEADBAND, 25'd0);
    write_reg(CFG_DT_LIMIT_US, 25'd1000000);
    write_reg(CFG_DT_SUBSTITUTE_US, 25'd0);
    write_reg(3'd7, 25'h1FFFFFF);
    random_samples(450);
    wait_idle();

    write_reg(CFG_BLEND_WEIGHT, 25'd65535);
    write_reg(CFG_YAW_RATE_DEADBAND, 25'd0);
    write_reg(CFG_ROLL_AXIS_DEADBAND, 25'd16777216);
    write_reg(CFG_DT_LIMIT_US, 25'd0);
    write_reg(CFG_DT_SUBSTITUTE_US, 25'd1000000);
    random_samples(450);
    wait_idle();

    write_reg(CFG_BLEND_WEIGHT, 25'h1FF0000 | 25'(16'($urandom())));
    write_reg(CFG_YAW_RATE_DEADBAND, 25'h1FFFFFF);
    write_reg(CFG_DT_LIMIT_US, 25'h1FFFFFF);
    write_reg(CFG_DT_SUBSTITUTE_US, 25'($urandom_range(0, 1000000)));
    random_samples(450);
    wait_idle();

    write_reg(CFG_BLEND_WEIGHT, 25'd64225);
    write_reg(CFG_YAW_RATE_DEADBAND, 25'd83886);
    write_reg(CFG_DT_LIMIT_US, 25'd30000);
    write_reg(CFG_DT_SUBSTITUTE_US, 25'd15000);
    random_samples(300);
    drain_phase = 1'b1;
    random_samples(150);

    wait_idle();
    $display("Checked %0d samples and %0d attitude items over five register settings,",
             samples_sent, results_seen);
    $display("including rate, interval and accelerometer extremes.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
